// File: rtl/core/isnap_pkg.sv
// Shared types and constants for the interval snap to frames block.
package isnap_pkg;

  localparam int MAX_FRAMES = 1024;
  localparam int FRAME_AW   = $clog2(MAX_FRAMES);
  localparam int FRAME_CW   = $clog2(MAX_FRAMES + 1);

  localparam int TIME_W  = 48;
  localparam int FRAC_W  = 17;
  localparam int COUNT_W = 16;

  localparam logic [FRAC_W-1:0]  FRAC_RESET = FRAC_W'(32768);
  localparam logic [COUNT_W-1:0] KEPT_MAX   = {COUNT_W{1'b1}};

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_LOAD   = 2'd1;
  localparam logic [1:0] OP_ADJUST = 2'd2;

  typedef struct packed {
    logic [1:0]               opcode;
    logic signed [TIME_W-1:0] first_time;
    logic signed [TIME_W-1:0] second_time;
  } isnap_in_t;

  typedef struct packed {
    logic signed [TIME_W-1:0] adjusted_start;
    logic signed [TIME_W-1:0] adjusted_stop;
    logic [COUNT_W-1:0]       kept_count;
  } isnap_out_t;

endpackage

// File: rtl/core/interval_snap_to_frames.sv
// Interval snap to frames: frame table, per-frame rule walk and snap compare.
//
// Usage:
//   in channel (in_valid/in_ready/in_data) takes one beat per command:
//   clear (empties the frame table, zeroes the kept counter), load (appends
//   one frame begin/end, ignored when the table is full) or adjust (walks
//   the loaded frames and snaps the interval start/stop).
//   out channel (out_valid/out_ready/out_data) carries one beat per adjust
//   that is kept and has start != stop, with a saturating kept count.
//   cfg channel (cfg_valid/cfg_ready/cfg_data) sets the exposure fraction;
//   write it only while the block is idle.
// Steps: clear and load complete in the idle state. Adjust walks each frame
//   through a frame RAM read and a rule decision, plus a multiply and a compare
//   step for each frame where a time is snapped (17x24 partial products,
//   then add and compare), and ends in a finish step.
//   The walk is serial because each frame's rules see the previous update.
// Reset: frame count, kept count and handshakes clear, exposure fraction
//   returns to one half; frame RAM contents are not cleared.
// Stall: a finished result sits in the output register; the next command
//   is accepted meanwhile, and a further result waits until it is taken.
module interval_snap_to_frames (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  isnap_pkg::isnap_in_t     in_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output isnap_pkg::isnap_out_t    out_data,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [isnap_pkg::FRAC_W-1:0] cfg_data
);
  import isnap_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_DECIDE,
    ST_MUL,
    ST_CMP,
    ST_FINISH
  } state_t;

  localparam int HALF_W = TIME_W / 2;
  localparam int PP_W   = FRAC_W + HALF_W;
  localparam int PROD_W = FRAC_W + TIME_W;

  state_t state;

  logic [2*TIME_W-1:0] mem [MAX_FRAMES];
  logic [2*TIME_W-1:0] rd_data;

  logic [FRAME_CW-1:0] frame_count;
  logic [FRAME_CW-1:0] m;
  logic [COUNT_W-1:0]  kept_total;
  logic [FRAC_W-1:0]   exposure_fraction;

  logic signed [TIME_W-1:0] b0;
  logic signed [TIME_W-1:0] el;
  logic signed [TIME_W-1:0] s_cur;
  logic signed [TIME_W-1:0] t_cur;
  logic signed [TIME_W-1:0] fb;
  logic signed [TIME_W-1:0] fe;
  logic [TIME_W-1:0]        num;
  logic [TIME_W-1:0]        den;
  logic                     snap_stop;
  logic                     dropped;
  logic [PP_W-1:0]          pp_hi;
  logic [PP_W-1:0]          pp_lo;

  // decision-stage signals
  logic signed [TIME_W-1:0] rb;
  logic signed [TIME_W-1:0] re;
  logic                     s_in, t_in, s_lt, t_gt, s_ge, t_le;
  logic [TIME_W:0]          num_s, num_t, den_w;
  logic                     last_frame;
  logic                     in_fire, mem_we, table_full;
  logic [PROD_W-1:0]        prod, lhs;
  logic                     over;
  logic signed [TIME_W-1:0] snapped;
  logic                     out_free, out_load;

  assign in_ready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;
  assign table_full = (frame_count == FRAME_CW'(MAX_FRAMES));
  assign mem_we    = in_fire && (in_data.opcode == OP_LOAD) && !table_full;
  assign out_free  = !out_valid || out_ready;
  assign out_load  = (state == ST_FINISH) && !dropped && (s_cur != t_cur) && out_free;

  assign rb = signed'(rd_data[2*TIME_W-1:TIME_W]);
  assign re = signed'(rd_data[TIME_W-1:0]);

  assign s_in = (s_cur >= rb) && (s_cur <= re);
  assign t_in = (t_cur >= rb) && (t_cur <= re);
  assign s_lt = (s_cur < b0);
  assign t_gt = (t_cur > el);
  assign s_ge = (s_cur >= el);
  assign t_le = (t_cur <= b0);

  // differences are non-negative inside a frame, so 48 bits hold them
  assign num_s = {re[TIME_W-1], re} - {s_cur[TIME_W-1], s_cur};
  assign num_t = {re[TIME_W-1], re} - {t_cur[TIME_W-1], t_cur};
  assign den_w = {re[TIME_W-1], re} - {rb[TIME_W-1], rb};

  assign last_frame = ((m + FRAME_CW'(1)) == frame_count);

  // exact compare: (E - t) * 2^16 > fraction * (E - B)
  assign prod = {pp_hi, {HALF_W{1'b0}}} + {{HALF_W{1'b0}}, pp_lo};
  assign lhs  = {{(PROD_W-TIME_W-16){1'b0}}, num, 16'd0};
  assign over = (lhs > prod);
  assign snapped = (den == '0) ? (snap_stop ? t_cur : s_cur) : (over ? fb : fe);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[frame_count[FRAME_AW-1:0]] <= {in_data.first_time, in_data.second_time};
    end
    rd_data <= mem[m[FRAME_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      frame_count       <= '0;
      kept_total        <= '0;
      exposure_fraction <= FRAC_RESET;
      out_valid         <= 1'b0;
      m                 <= '0;
      dropped           <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        exposure_fraction <= cfg_data;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            s_cur   <= in_data.first_time;
            t_cur   <= in_data.second_time;
            dropped <= 1'b0;
            m       <= '0;
            case (in_data.opcode)
              OP_CLEAR: begin
                frame_count <= '0;
                kept_total  <= '0;
              end
              OP_LOAD: begin
                if (!table_full) begin
                  if (frame_count == '0) begin
                    b0 <= in_data.first_time;
                  end
                  el          <= in_data.second_time;
                  frame_count <= frame_count + FRAME_CW'(1);
                end
              end
              OP_ADJUST: begin
                state <= (frame_count == '0) ? ST_FINISH : ST_FETCH;
              end
              default: ;
            endcase
          end
        end

        ST_FETCH: begin
          state <= ST_DECIDE;
        end

        ST_DECIDE: begin
          fb  <= rb;
          fe  <= re;
          den <= den_w[TIME_W-1:0];
          if (s_in) begin
            snap_stop <= 1'b0;
            num       <= num_s[TIME_W-1:0];
            state     <= ST_MUL;
          end else if (t_in && !s_lt) begin
            snap_stop <= 1'b1;
            num       <= num_t[TIME_W-1:0];
            state     <= ST_MUL;
          end else if (!s_lt && !t_gt && (s_ge || t_le)) begin
            dropped <= 1'b1;
            state   <= ST_FINISH;
          end else begin
            if (s_lt) begin
              s_cur <= b0;
            end else if (t_gt) begin
              t_cur <= el;
            end
            m     <= m + FRAME_CW'(1);
            state <= last_frame ? ST_FINISH : ST_FETCH;
          end
        end

        ST_MUL: begin
          pp_hi <= exposure_fraction * den[TIME_W-1:HALF_W];
          pp_lo <= exposure_fraction * den[HALF_W-1:0];
          state <= ST_CMP;
        end

        ST_CMP: begin
          if (snap_stop) begin
            t_cur <= snapped;
          end else begin
            s_cur <= snapped;
          end
          m     <= m + FRAME_CW'(1);
          state <= last_frame ? ST_FINISH : ST_FETCH;
        end

        ST_FINISH: begin
          if (dropped || (s_cur == t_cur)) begin
            state <= ST_IDLE;
          end else if (out_free) begin
            out_data.adjusted_start <= s_cur;
            out_data.adjusted_stop  <= t_cur;
            out_data.kept_count     <= (kept_total == KEPT_MAX) ? KEPT_MAX
                                       : kept_total + COUNT_W'(1);
            if (kept_total != KEPT_MAX) begin
              kept_total <= kept_total + COUNT_W'(1);
            end
            state <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

  // table never overfills
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    frame_count <= FRAME_CW'(MAX_FRAMES))
    else $error("frame count beyond table depth");

  // the walk only reads loaded entries
  a_walk_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FETCH) |-> (m < frame_count))
    else $error("frame walk past last loaded frame");

  // a new result beat always carries a nonzero kept count
  a_kept_nonzero: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> (out_data.kept_count != '0))
    else $error("result beat with zero kept count");

  // a pending result is not overwritten by a later interval
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("pending result beat lost");

endmodule

// File: tb/sv/testbench.sv
// Testbench for interval_snap_to_frames: directed and random commands checked against a predictor.
`timescale 1ns / 1ps

module testbench;
  import isnap_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam longint TIME_MIN = -(64'sd1 <<< 47);
  localparam longint TIME_MAX = (64'sd1 <<< 47) - 1;
  localparam int LONG_TABLE = 64;
  // watchdog for a run of a few hundred beats with walks of up to 64 frames
  localparam int CYCLE_LIMIT = 2_000_000;

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_ready;
  isnap_in_t in_data;
  logic out_valid;
  logic out_ready;
  isnap_out_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [FRAC_W-1:0] cfg_data;

  interval_snap_to_frames i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always #10 clk = ~clk;

  // predictor state
  logic signed [TIME_W-1:0] frame_begins [MAX_FRAMES];
  logic signed [TIME_W-1:0] frame_ends [MAX_FRAMES];
  int                       frames_loaded = 0;
  logic [COUNT_W-1:0]       kept_so_far = '0;
  logic [FRAC_W-1:0]        exposure_frac = FRAC_RESET;
  int                       longest_walk = 0;
  isnap_out_t               pending_intervals [$];

  int   mismatches = 0;
  int   items_sent = 0;
  int   hold_off_cycles = 0;
  bit   steady = 1'b0;
  int   cycle_count = 0;
  isnap_out_t due;

  function automatic logic [TIME_W-1:0] rand48();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[TIME_W-1:0];
  endfunction

  function automatic logic [TIME_W-1:0] secs(input int n);
    longint v;
    v = longint'(n) <<< 16;
    return v[TIME_W-1:0];
  endfunction

  // begin if the tail of the frame past t exceeds the exposure share, else end; t for an empty frame
  function automatic logic signed [TIME_W-1:0] snap_time(input logic signed [TIME_W-1:0] t,
                                                         input logic signed [TIME_W-1:0] fb,
                                                         input logic signed [TIME_W-1:0] fe);
    longint lb, le, lt;
    logic [63:0] span_u, rest_u;
    logic [127:0] lhs, rhs;
    lb = longint'(fb);
    le = longint'(fe);
    lt = longint'(t);
    span_u = le - lb;
    rest_u = le - lt;
    if (span_u == '0) return t;
    lhs = {64'd0, rest_u} << 16;
    rhs = 128'(exposure_frac) * 128'(span_u);
    return (lhs > rhs) ? fb : fe;
  endfunction

  task automatic predict_command(input isnap_in_t cmd);
    logic signed [TIME_W-1:0] s, t, first_begin, last_end, fb, fe;
    bit dropped;
    int m;
    isnap_out_t r;
    case (cmd.opcode)
      OP_CLEAR: begin
        frames_loaded = 0;
        kept_so_far = '0;
      end
      OP_LOAD: begin
        if (frames_loaded < MAX_FRAMES) begin
          frame_begins[frames_loaded] = cmd.first_time;
          frame_ends[frames_loaded] = cmd.second_time;
          frames_loaded++;
        end
      end
      OP_ADJUST: begin
        s = cmd.first_time;
        t = cmd.second_time;
        dropped = 1'b0;
        if (frames_loaded > longest_walk) longest_walk = frames_loaded;
        if (frames_loaded > 0) begin
          first_begin = frame_begins[0];
          last_end = frame_ends[frames_loaded-1];
          for (m = 0; m < frames_loaded && !dropped; m++) begin
            fb = frame_begins[m];
            fe = frame_ends[m];
            if (s >= fb && s <= fe) s = snap_time(s, fb, fe);
            else if (s < first_begin) s = first_begin;
            else if (t >= fb && t <= fe) t = snap_time(t, fb, fe);
            else if (t > last_end) t = last_end;
            else if (s >= last_end) dropped = 1'b1;
            else if (t <= first_begin) dropped = 1'b1;
          end
        end
        if (!dropped && s != t) begin
          if (kept_so_far < KEPT_MAX) kept_so_far++;
          r.adjusted_start = s;
          r.adjusted_stop = t;
          r.kept_count = kept_so_far;
          pending_intervals.push_back(r);
        end
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endtask

  // valid stays high across back-to-back beats; only lowered before a gap
  task automatic send_command(input logic [1:0] op, input logic [TIME_W-1:0] a,
                              input logic [TIME_W-1:0] b);
    isnap_in_t cmd;
    int gap;
    cmd.opcode = op;
    cmd.first_time = a;
    cmd.second_time = b;
    gap = steady ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= cmd;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_command(cmd);
    items_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_intervals.size() > 0) @(posedge clk);
    // a dropped interval may still be walking the table
    repeat (4 * longest_walk + 8) @(posedge clk);
    longest_walk = frames_loaded;
  endtask

  task automatic write_fraction(input logic [FRAC_W-1:0] v);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    exposure_frac = v;
  endtask

  function automatic logic [TIME_W-1:0] pick_time();
    int k;
    longint fb, fe, span;
    logic [63:0] off;
    logic [TIME_W-1:0] v;
    if (frames_loaded == 0) return rand48();
    k = $urandom_range(0, frames_loaded - 1);
    fb = longint'(frame_begins[k]);
    fe = longint'(frame_ends[k]);
    span = fe - fb;
    case ($urandom_range(0, 9))
      0: v = TIME_W'(fb);
      1: v = TIME_W'(fe);
      2: v = TIME_W'(fb - 1);
      3: v = TIME_W'(fe + 1);
      4: v = TIME_W'(longint'(frame_begins[0]) -
                     longint'($urandom_range(1, 1 << 20)));
      5: v = TIME_W'(longint'(frame_ends[frames_loaded-1]) +
                     longint'($urandom_range(1, 1 << 20)));
      6: v = rand48();
      default: begin
        if (span > 0) begin
          off = {$urandom, $urandom} % (span + 1);
          v = TIME_W'(fb + longint'(off));
        end else begin
          v = TIME_W'(fb);
        end
      end
    endcase
    return v;
  endfunction

  task automatic send_random_interval();
    logic signed [TIME_W-1:0] s, t, x;
    s = pick_time();
    t = pick_time();
    if ($urandom_range(0, 3) != 0 && s > t) begin
      x = s;
      s = t;
      t = x;
    end
    if ($urandom_range(0, 15) == 0) t = s;
    send_command(OP_ADJUST, s, t);
  endtask

  // clear, a run of frames, then intervals around them with some noise mixed in
  task automatic run_session();
    int n_frames, n_adj, place, k, r;
    longint base, total, fb, fe, len, gap;
    longint lens [$];
    longint gaps [$];
    steady = ($urandom_range(0, 5) == 0);
    case ($urandom_range(0, 9))
      0: n_frames = 0;
      1: n_frames = $urandom_range(9, 40);
      default: n_frames = $urandom_range(1, 8);
    endcase
    total = '0;
    for (k = 0; k < n_frames; k++) begin
      case ($urandom_range(0, 9))
        0: len = '0;
        1, 2: len = longint'($urandom_range(1, 16));
        default: len = longint'($urandom_range(1, 1 << 24));
      endcase
      gap = '0;
      if (k != 0 && $urandom_range(0, 3) != 0) gap = longint'($urandom_range(1, 1 << 20));
      lens.push_back(len);
      gaps.push_back(gap);
      total += len + gap;
    end
    place = $urandom_range(0, 7);
    if (place == 0) base = TIME_MIN;
    else if (place == 1) base = TIME_MAX - total;
    else base = longint'($signed(rand48())) >>> 2;
    send_command(OP_CLEAR, rand48(), rand48());
    fb = base;
    for (k = 0; k < n_frames; k++) begin
      fb += gaps[k];
      fe = fb + lens[k];
      if ($urandom_range(0, 14) == 0) send_command(OP_LOAD, rand48(), rand48());
      else send_command(OP_LOAD, TIME_W'(fb), TIME_W'(fe));
      fb = fe;
    end
    n_adj = $urandom_range(2, 10);
    for (k = 0; k < n_adj; k++) begin
      r = $urandom_range(0, 19);
      if (r == 0) send_command(OP_CLEAR, rand48(), rand48());
      else if (r == 1) send_command(OP_LOAD, pick_time(), pick_time());
      else send_random_interval();
    end
    if ($urandom_range(0, 5) == 0) wait_drained();
    steady = 1'b0;
  endtask

  task automatic test_no_frames();
    send_command(OP_CLEAR, '0, '0);
    send_command(OP_ADJUST, TIME_W'(TIME_MIN), TIME_W'(TIME_MAX));
    send_command(OP_ADJUST, TIME_W'(TIME_MAX), TIME_W'(TIME_MIN));
    send_command(OP_ADJUST, secs(5), secs(5));
    send_command(OP_UNUSED, TIME_W'(TIME_MAX), TIME_W'(TIME_MIN));
    send_command(OP_ADJUST, secs(-3), secs(7));
  endtask

  task automatic test_rule_chain();
    send_command(OP_CLEAR, TIME_W'(TIME_MAX), TIME_W'(TIME_MIN));
    send_command(OP_LOAD, secs(10), secs(20));
    send_command(OP_LOAD, secs(20), secs(30));
    send_command(OP_LOAD, secs(40), secs(40));
    send_command(OP_LOAD, secs(50), secs(60));
    send_command(OP_ADJUST, secs(12), secs(58));
    send_command(OP_ADJUST, secs(18), secs(52));
    send_command(OP_ADJUST, secs(5), secs(25));
    send_command(OP_ADJUST, secs(35), secs(38));
    send_command(OP_ADJUST, secs(65), secs(70));
    send_command(OP_ADJUST, secs(0), secs(8));
    send_command(OP_ADJUST, secs(40), secs(45));
    send_command(OP_ADJUST, secs(22), secs(22));
    send_command(OP_ADJUST, TIME_W'(TIME_MIN), TIME_W'(TIME_MAX));
    send_command(OP_UNUSED, secs(12), secs(58));
    send_command(OP_ADJUST, secs(15), secs(15) + TIME_W'(1));
  endtask

  task automatic test_long_table();
    int k;
    longint fb, len;
    send_command(OP_CLEAR, '0, '0);
    for (k = 0; k < LONG_TABLE; k++) begin
      fb = (longint'(k) <<< 20) + longint'($urandom_range(0, 1 << 18));
      len = ($urandom_range(0, 7) == 0) ? '0 : longint'($urandom_range(1, 1 << 19));
      send_command(OP_LOAD, TIME_W'(fb), TIME_W'(fb + len));
    end
    for (k = 0; k < 4; k++) send_random_interval();
    wait_drained();
  endtask

  task automatic test_backpressure();
    int k;
    send_command(OP_CLEAR, '0, '0);
    send_command(OP_LOAD, secs(1), secs(4));
    send_command(OP_LOAD, secs(6), secs(9));
    steady = 1'b1;
    hold_off_cycles = 300;
    for (k = 0; k < 12; k++)
      send_command(OP_ADJUST, secs(2) + TIME_W'(k), secs(8) - TIME_W'(k));
    steady = 1'b0;
    wait_drained();
  endtask

  task automatic test_random_phases();
    logic [FRAC_W-1:0] settings [6];
    int p, target;
    settings[0] = 17'd65536;
    settings[1] = 17'd0;
    settings[2] = 17'd1;
    settings[3] = 17'd65535;
    settings[4] = FRAC_W'($urandom_range(0, 65536));
    settings[5] = FRAC_RESET;
    target = items_sent;
    for (p = 0; p < 6; p++) begin
      write_fraction(settings[p]);
      target += 75;
      while (items_sent < target) run_session();
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_no_frames();
    test_rule_chain();
    test_long_table();
    test_backpressure();
    test_random_phases();
    wait_drained();
    if (mismatches == 0 && pending_intervals.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // result side: random stalls per beat, plus one long hold-off on request
  initial begin
    int stall;
    out_ready = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (hold_off_cycles > 0) begin
        out_ready <= 1'b0;
        repeat (hold_off_cycles) @(posedge clk);
        hold_off_cycles = 0;
      end else begin
        stall = steady ? 0 : $urandom_range(0, 5);
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_intervals.size() == 0) begin
        report_mismatch($sformatf("unexpected beat: start=%0d stop=%0d count=%0d",
                                  out_data.adjusted_start, out_data.adjusted_stop,
                                  out_data.kept_count));
      end else begin
        due = pending_intervals.pop_front();
        if (out_data.adjusted_start !== due.adjusted_start)
          report_mismatch($sformatf("adjusted_start: expected %0d, got %0d",
                                    due.adjusted_start, out_data.adjusted_start));
        if (out_data.adjusted_stop !== due.adjusted_stop)
          report_mismatch($sformatf("adjusted_stop: expected %0d, got %0d",
                                    due.adjusted_stop, out_data.adjusted_stop));
        if (out_data.kept_count !== due.kept_count)
          report_mismatch($sformatf("kept_count: expected %0d, got %0d",
                                    due.kept_count, out_data.kept_count));
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

endmodule
